// ----- hw/rtl/spq_pkg.sv -----
// Shared types and codes for the stable priority queue.
package spq_pkg;

   localparam int unsigned STATUS_BITS = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   localparam logic ACTION_ENQUEUE = 1'b0;
   localparam logic ACTION_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;   // latch the incoming request
      logic apply;     // update the cell array and load the result
   } cmd_type;

endpackage

// ----- hw/rtl/spq_ctrl.sv -----
// Request sequencer: accept, apply, deliver.
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output spq_pkg::cmd_type cmd
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = spq_pkg::ST_APPLY;
            end
         end
         spq_pkg::ST_APPLY: begin
            state_in = spq_pkg::ST_SEND;
         end
         spq_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.capture = 1'b0;
      cmd.apply   = 1'b0;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         spq_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         spq_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   a_apply_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.apply)
      else $error("apply did not follow capture");

   a_send_after_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_tvalid)
      else $error("result not presented after apply");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready && !cmd.apply)
      else $error("request taken while a result is pending");

endmodule

// ----- hw/rtl/spq_datapath.sv -----
// Sorted cell array with request and result registers.
module spq_datapath #(
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned VALUE_BITS    = 8,
   parameter int unsigned PRIORITY_BITS = 4,
   parameter int unsigned COUNT_BITS    = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spq_pkg::cmd_type                cmd,
   input  logic                            in_action,
   input  logic [VALUE_BITS-1:0]           in_value,
   input  logic [PRIORITY_BITS-1:0]        in_priority,
   output logic [spq_pkg::STATUS_BITS-1:0] res_status,
   output logic [VALUE_BITS-1:0]           res_value,
   output logic [PRIORITY_BITS-1:0]        res_priority,
   output logic [COUNT_BITS-1:0]           res_occupancy
);

   // captured request
   logic                     act_ff;
   logic [VALUE_BITS-1:0]    val_ff;
   logic [PRIORITY_BITS-1:0] pri_ff;

   // cell array, front at index 0
   logic [VALUE_BITS-1:0]    cell_val_ff [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_pri_ff [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]    cell_val_in [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_pri_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   keep;      // cell holds an entry that stays ahead

   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;

   logic [spq_pkg::STATUS_BITS-1:0] status_ff;
   logic [spq_pkg::STATUS_BITS-1:0] status_in;
   logic [VALUE_BITS-1:0]           rval_ff;
   logic [VALUE_BITS-1:0]           rval_in;
   logic [PRIORITY_BITS-1:0]        rpri_ff;
   logic [PRIORITY_BITS-1:0]        rpri_in;

   logic is_full;
   logic is_empty;

   assign is_full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= in_action;
         val_ff <= in_value;
         pri_ff <= in_priority;
      end
   end

   // each cell compares against the new priority in parallel
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (COUNT_BITS'(i) < count_ff) && (cell_pri_ff[i] >= pri_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_val_in[i] = cell_val_ff[i];
         cell_pri_in[i] = cell_pri_ff[i];
         if (act_ff == spq_pkg::ACTION_ENQUEUE) begin
            priority if (i > 0 && !keep[(i > 0) ? i - 1 : 0]) begin
               cell_val_in[i] = cell_val_ff[(i > 0) ? i - 1 : 0];
               cell_pri_in[i] = cell_pri_ff[(i > 0) ? i - 1 : 0];
            end else if (!keep[i]) begin
               cell_val_in[i] = val_ff;
               cell_pri_in[i] = pri_ff;
            end else begin
               cell_val_in[i] = cell_val_ff[i];
               cell_pri_in[i] = cell_pri_ff[i];
            end
         end else if (i < QUEUE_DEPTH - 1) begin
            cell_val_in[i] = cell_val_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            cell_pri_in[i] = cell_pri_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::STATUS_DONE;
      rval_in   = '0;
      rpri_in   = '0;
      if (act_ff == spq_pkg::ACTION_ENQUEUE) begin
         if (is_full) begin
            status_in = spq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (is_empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            count_in = count_ff - 1'b1;
            rval_in  = cell_val_ff[0];
            rpri_in  = cell_pri_ff[0];
         end
      end
   end

   logic shift_en;
   assign shift_en = cmd.apply &&
      ((act_ff == spq_pkg::ACTION_ENQUEUE) ? !is_full : !is_empty);

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cell_val_ff[i] <= cell_val_in[i];
            cell_pri_ff[i] <= cell_pri_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff <= status_in;
         rval_ff   <= rval_in;
         rpri_ff   <= rpri_in;
      end
   end

   assign res_status    = status_ff;
   assign res_value     = rval_ff;
   assign res_priority  = rpri_ff;
   assign res_occupancy = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff > COUNT_BITS'(1) |-> cell_pri_ff[0] >= cell_pri_ff[1])
      else $error("front entries out of priority order");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && act_ff == spq_pkg::ACTION_ENQUEUE && !is_full
      |=> count_ff == COUNT_BITS'($past(count_ff) + 1'b1))
      else $error("enqueue did not grow the queue");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && act_ff == spq_pkg::ACTION_DEQUEUE && is_empty
      |=> res_status == spq_pkg::STATUS_EMPTY && res_occupancy == '0)
      else $error("empty dequeue misreported");

endmodule

// ----- hw/rtl/stable_priority_queue_top.sv -----
// Top level of the stable priority queue: sequencer plus sorted cell array.
//
//   channel | direction | tdata (low bit up)                     | tuser
//   --------+-----------+----------------------------------------+---------------
//   req_    | in        | value, priority_req                    | action
//   rsp_    | out       | out_value, out_priority, occupancy     | status
//
// Each request passes through accept, apply to the cell array and present the
// result; the sequencer serializes them, so requests do not overlap.
// The cell array updates every entry at once: on enqueue each cell compares
// its priority with the new one and keeps, shifts or loads; on dequeue every
// entry moves one place toward the front.
// Reset (synchronous, active high) clears the sequencer and the entry count;
// the cell contents need no clearing since only counted cells are read.
// A stalled result holds rsp_tdata and rsp_tuser; no new request is taken
// until it is delivered.
module stable_priority_queue_top #(
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned VALUE_BITS    = 8,
   parameter int unsigned PRIORITY_BITS = 4
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // value, priority_req, zero fill
   input  logic [((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // action
   input  logic req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_value, out_priority, occupancy, zero fill
   output logic [((VALUE_BITS + PRIORITY_BITS + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8
                 - 1:0] rsp_tdata,
   // status
   output logic [spq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   localparam int unsigned COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned RSP_DATA_BITS =
      ((VALUE_BITS + PRIORITY_BITS + COUNT_BITS + 7) / 8) * 8;

   spq_pkg::cmd_type cmd;

   logic [VALUE_BITS-1:0]    res_value;
   logic [PRIORITY_BITS-1:0] res_priority;
   logic [COUNT_BITS-1:0]    res_occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_action     (req_tuser),
      .in_value      (req_tdata[VALUE_BITS-1:0]),
      .in_priority   (req_tdata[VALUE_BITS +: PRIORITY_BITS]),
      .res_status    (rsp_tuser),
      .res_value     (res_value),
      .res_priority  (res_priority),
      .res_occupancy (res_occupancy)
   );

   assign rsp_tdata = RSP_DATA_BITS'({res_occupancy, res_priority, res_value});

endmodule
